[hw/rtl/chunk_receive_window_core_defines.svh]
// Assertion macros shared by the receive window RTL.
// Each macro takes a label, the clock and the property body; CRW_ASSERT also takes the reset.
`ifndef CHUNK_RECEIVE_WINDOW_CORE_DEFINES_SVH
`define CHUNK_RECEIVE_WINDOW_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset.
`define CRW_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: check failed");

// Property checked at every rising edge, during reset as well.
`define CRW_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("%m: check failed");

`else

`define CRW_ASSERT(lbl, clk, rst, prop)
`define CRW_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hw/rtl/crw_pkg.sv]
package crw_pkg;

   // Window geometry and result limit.
   localparam int WINDOW_SLOTS_DEF = 64;
   localparam int MAX_RESULTS      = 64;
   localparam int CNT_W            = $clog2(MAX_RESULTS + 1);

   // Field widths.
   localparam int IDX_W   = 32;
   localparam int LEN_W   = 17;
   localparam int DELAY_W = 16;
   localparam int OP_W    = 2;
   localparam int KIND_W  = 3;
   localparam int DIV_STEPS = 32;

   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [OP_W-1:0]   op_type;

   // Operation codes.
   localparam op_type OP_ARRIVE = 2'd0;
   localparam op_type OP_TICK   = 2'd1;
   localparam op_type OP_DRAIN  = 2'd2;

   // Result kinds.
   localparam kind_type KIND_ACCEPTED = 3'd0;
   localparam kind_type KIND_IGNORED  = 3'd1;
   localparam kind_type KIND_WANT     = 3'd2;
   localparam kind_type KIND_RELEASED = 3'd3;
   localparam kind_type KIND_NONE     = 3'd4;

   // Register indexes.
   localparam logic [1:0] REG_TOTAL_CHUNKS  = 2'd0;
   localparam logic [1:0] REG_CHUNK_BYTES   = 2'd1;
   localparam logic [1:0] REG_FILE_BYTES    = 2'd2;
   localparam logic [1:0] REG_REQUEST_DELAY = 2'd3;

   // Register reset values and limits.
   localparam logic [IDX_W-1:0]   TOTAL_CHUNKS_RST  = 32'd1;
   localparam logic [LEN_W-1:0]   CHUNK_BYTES_RST   = 17'd1024;
   localparam logic [LEN_W-1:0]   CHUNK_BYTES_MAX   = 17'd65536;
   localparam logic [IDX_W-1:0]   FILE_BYTES_RST    = 32'd0;
   localparam logic [DELAY_W-1:0] REQUEST_DELAY_RST = 16'd35;

endpackage

[hw/rtl/chunk_receive_window_core.sv]
// Receive window for a selective-repeat chunk transfer.
// Input words are commands: start with req_op, req_chunk_index and req_now_tick
// is taken at a rising edge where busy is low; busy then stays high until the
// last result word of that command has been loaded into the result register.
// Each result word appears on the rsp_ ports for exactly one cycle with
// rsp_valid high; rsp_last marks the final word of a command. The receiver
// cannot stall, so nothing is held back.
// Sequence and rate: an arrival passes S_ARR_CHK and S_ARR_SET and gives
// its single word. A request tick walks the window one slot per cycle
// through one shared compare, up to WINDOW_SLOTS slots. A drain first runs a
// 32-step restoring remainder unit for the last chunk length, then releases
// one chunk per cycle. A command that does nothing answers with a single
// KIND_NONE word. The next command can start in the cycle in which the
// final word is shown.
// Configuration goes through the APB-style port at any time the block is idle.
// Reset clears the window base, the received bitmap and the request schedule
// at once and loads the register defaults; no clearing pass is needed.
`include "chunk_receive_window_core_defines.svh"

module chunk_receive_window_core
   import crw_pkg::*;
#(
   parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // Command channel
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_op,
   input  logic [IDX_W-1:0]   req_chunk_index,
   input  logic [IDX_W-1:0]   req_now_tick,
   // Result channel
   output logic               rsp_valid,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [IDX_W-1:0]   rsp_index,
   output logic [LEN_W-1:0]   rsp_length,
   output logic               rsp_done_res,
   output logic               rsp_last,
   // Configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam logic [IW-1:0]      LAST_SLOT  = IW'(WINDOW_SLOTS - 1);
   localparam logic [IDX_W-1:0]   SLOTS_W    = IDX_W'(WINDOW_SLOTS);
   localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(MAX_RESULTS - 1);
   localparam logic [4:0]         DIV_LAST   = 5'(DIV_STEPS - 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ARR_CHK  = 3'd1;
   localparam logic [2:0] S_ARR_SET  = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_SCAN_FIN = 3'd4;
   localparam logic [2:0] S_DIV      = 3'd5;
   localparam logic [2:0] S_DRAIN    = 3'd6;
   localparam logic [2:0] S_NONE     = 3'd7;

   // Configuration registers.
   logic [IDX_W-1:0]   total_ff;
   logic [LEN_W-1:0]   cbytes_ff;
   logic [IDX_W-1:0]   fbytes_ff;
   logic [DELAY_W-1:0] delay_ff;

   // Window state.
   logic [2:0]              state_ff, state_in;
   logic [IDX_W-1:0]        base_ff, base_in;
   logic [WINDOW_SLOTS-1:0] map_ff, map_in;
   logic [IDX_W-1:0]        next_tick_ff, next_tick_in;

   // Working registers of the sequencer.
   logic [IDX_W:0]          idx_ff, idx_in;
   logic [IW-1:0]           slot_ff, slot_in;
   logic [WINDOW_SLOTS-1:0] scan_map_ff, scan_map_in;
   logic [IDX_W-1:0]        pend_ff, pend_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IW-1:0]           rel_ff, rel_in;
   logic                    win_ok_ff, win_ok_in;
   logic [LEN_W-1:0]        rem_ff, rem_in;
   logic [IDX_W-1:0]        div_q_ff, div_q_in;
   logic [4:0]              div_cnt_ff, div_cnt_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [LEN_W-1:0]   rsp_length_ff, rsp_length_in;
   logic               rsp_done_ff, rsp_done_in;
   logic               rsp_last_ff, rsp_last_in;

   // Shared helpers.
   logic               cfg_wr;
   logic [LEN_W-1:0]   cbytes_wr;
   logic               accept;
   logic               done_now;
   logic [IDX_W-1:0]   diff;
   logic               in_range;
   logic               miss;
   logic [LEN_W:0]     div_trial;
   logic [IDX_W:0]     base_plus;
   logic               last_chunk;
   logic [WINDOW_SLOTS-1:0] rel_hot;

   assign accept   = start && (state_ff == S_IDLE);
   assign busy     = (state_ff != S_IDLE);
   assign done_now = (base_ff >= total_ff);
   assign diff      = idx_ff[IDX_W-1:0] - base_ff;
   assign in_range  = (idx_ff < {1'b0, total_ff});
   assign miss      = in_range && !scan_map_ff[0];
   assign div_trial = {rem_ff, div_q_ff[IDX_W-1]};
   assign base_plus = {1'b0, base_ff} + 33'd1;
   assign last_chunk = (base_plus >= {1'b0, total_ff});
   assign rel_hot    = WINDOW_SLOTS'(1) << rel_ff;

   // Configuration port: zero-wait writes, register readback.
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      cbytes_wr = pwdata[LEN_W-1:0];
      if (cbytes_wr == '0) begin
         cbytes_wr = 17'd1;
      end else if (cbytes_wr > CHUNK_BYTES_MAX) begin
         cbytes_wr = CHUNK_BYTES_MAX;
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_TOTAL_CHUNKS:  prdata = total_ff;
         REG_CHUNK_BYTES:   prdata = {15'd0, cbytes_ff};
         REG_FILE_BYTES:    prdata = fbytes_ff;
         REG_REQUEST_DELAY: prdata = {16'd0, delay_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= TOTAL_CHUNKS_RST;
         cbytes_ff <= CHUNK_BYTES_RST;
         fbytes_ff <= FILE_BYTES_RST;
         delay_ff  <= REQUEST_DELAY_RST;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_TOTAL_CHUNKS:  total_ff  <= (pwdata == '0) ? 32'd1 : pwdata;
            REG_CHUNK_BYTES:   cbytes_ff <= cbytes_wr;
            REG_FILE_BYTES:    fbytes_ff <= pwdata;
            REG_REQUEST_DELAY: delay_ff  <= pwdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: each state evaluates the compares and subtracts that it needs.
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      map_in        = map_ff;
      next_tick_in  = next_tick_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      scan_map_in   = scan_map_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      count_in      = count_ff;
      rel_in        = rel_ff;
      win_ok_in     = win_ok_ff;
      rem_in        = rem_ff;
      div_q_in      = div_q_ff;
      div_cnt_in    = div_cnt_ff;

      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_length_in = rsp_length_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_ARRIVE: begin
                     idx_in   = {1'b0, req_chunk_index};
                     state_in = S_ARR_CHK;
                  end
                  OP_TICK: begin
                     if (!done_now && (req_now_tick >= next_tick_ff)) begin
                        next_tick_in  = req_now_tick + {16'd0, delay_ff};
                        idx_in        = {1'b0, base_ff};
                        slot_in       = '0;
                        scan_map_in   = map_ff;
                        pend_valid_in = 1'b0;
                        count_in      = '0;
                        state_in      = S_SCAN;
                     end else begin
                        state_in = S_NONE;
                     end
                  end
                  OP_DRAIN: begin
                     if (map_ff[0]) begin
                        rem_in     = '0;
                        div_q_in   = fbytes_ff;
                        div_cnt_in = '0;
                        state_in   = S_DIV;
                     end else begin
                        state_in = S_NONE;
                     end
                  end
                  default: state_in = S_NONE;
               endcase
            end
         end

         // Window test for an arriving chunk.
         S_ARR_CHK: begin
            win_ok_in = (idx_ff[IDX_W-1:0] >= base_ff) && (diff < SLOTS_W) && in_range;
            rel_in    = diff[IW-1:0];
            state_in  = S_ARR_SET;
         end

         S_ARR_SET: begin
            rsp_valid_in  = 1'b1;
            rsp_index_in  = '0;
            rsp_length_in = '0;
            rsp_done_in   = done_now;
            rsp_last_in   = 1'b1;
            if (win_ok_ff && !(|(map_ff & rel_hot))) begin
               map_in      = map_ff | rel_hot;
               rsp_kind_in = KIND_ACCEPTED;
            end else begin
               rsp_kind_in = KIND_IGNORED;
            end
            state_in = S_IDLE;
         end

         // One slot per cycle; a found index waits in pend until the next found index
         // or the end of the scan shows whether it is the last word.
         S_SCAN: begin
            if (miss) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_WANT;
                  rsp_index_in  = pend_ff;
                  rsp_length_in = '0;
                  rsp_done_in   = done_now;
                  rsp_last_in   = 1'b0;
               end
               pend_in       = idx_ff[IDX_W-1:0];
               pend_valid_in = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
            if (!in_range || (slot_ff == LAST_SLOT) || (miss && (count_ff == CNT_LAST))) begin
               state_in = S_SCAN_FIN;
            end else begin
               slot_in     = slot_ff + IW'(1);
               idx_in      = idx_ff + 33'd1;
               scan_map_in = scan_map_ff >> 1;
            end
         end

         S_SCAN_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = pend_valid_ff ? KIND_WANT : KIND_NONE;
            rsp_index_in  = pend_valid_ff ? pend_ff : '0;
            rsp_length_in = '0;
            rsp_done_in   = done_now;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         // Restoring remainder of file size by chunk size, one bit a cycle.
         S_DIV: begin
            if (div_trial >= {1'b0, cbytes_ff}) begin
               rem_in = LEN_W'(div_trial - {1'b0, cbytes_ff});
            end else begin
               rem_in = div_trial[LEN_W-1:0];
            end
            div_q_in   = div_q_ff << 1;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_LAST) begin
               count_in = '0;
               state_in = S_DRAIN;
            end
         end

         // Release one in-order chunk a cycle and slide the window.
         S_DRAIN: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_RELEASED;
            rsp_index_in  = base_ff;
            rsp_length_in = last_chunk ? rem_ff : cbytes_ff;
            rsp_done_in   = last_chunk;
            rsp_last_in   = !map_ff[1] || (count_ff == CNT_LAST);
            base_in       = base_plus[IDX_W-1:0];
            map_in        = map_ff >> 1;
            count_in      = count_ff + CNT_W'(1);
            if (!map_ff[1] || (count_ff == CNT_LAST)) begin
               state_in = S_IDLE;
            end
         end

         S_NONE: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_NONE;
            rsp_index_in  = '0;
            rsp_length_in = '0;
            rsp_done_in   = done_now;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state and window state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_ff       <= '0;
         map_ff        <= '0;
         next_tick_ff  <= '0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         map_ff        <= map_in;
         next_tick_ff  <= next_tick_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      slot_ff       <= slot_in;
      scan_map_ff   <= scan_map_in;
      pend_ff       <= pend_in;
      rel_ff        <= rel_in;
      win_ok_ff     <= win_ok_in;
      rem_ff        <= rem_in;
      div_q_ff      <= div_q_in;
      div_cnt_ff    <= div_cnt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_length_ff <= rsp_length_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_last     = rsp_last_ff;

   // A word that is not the last of its command leaves the block busy.
   `CRW_ASSERT(a_mid_word_busy, clock, reset, (rsp_valid_ff && !rsp_last_ff) |-> busy)
   // A taken command makes the block busy in the next cycle.
   `CRW_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy)
   // The drain only runs while the window base slot holds a chunk.
   `CRW_ASSERT(a_drain_head, clock, reset, (state_ff == S_DRAIN) |-> map_ff[0])
   // The result count never passes the per-command limit.
   `CRW_ASSERT(a_count_limit, clock, reset, count_ff <= CNT_W'(MAX_RESULTS))
   // A "nothing to do" word always closes its command.
   `CRW_ASSERT(a_none_last, clock, reset,
      (rsp_valid_ff && (rsp_kind_ff == KIND_NONE)) |-> rsp_last_ff)

endmodule
